FILE: rtl/mlws_pkg.sv
// ----------------------------------------------------------------------------
// mlws_pkg - shared types for the mutex lock with wait stack
// Command, status and phase codes, request and response items, and sizes.
// ----------------------------------------------------------------------------
package mlws_pkg;

	// Width of a thread identifier; zero means no thread
	localparam int TID_W = 8;

	// Default number of entries in the wait stack
	localparam int WAIT_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		CMD_LOCK   = 2'd0,
		CMD_TRY    = 2'd1,
		CMD_UNLOCK = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_BUSY      = 3'd2,
		ST_NOT_OWNER = 3'd3,
		ST_NO_THREAD = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_UNLOCKED  = 2'd0,
		PH_LOCKED    = 2'd1,
		PH_CONTENDED = 2'd2
	} phase_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [TID_W-1:0] thread_id;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic             woken_valid;
		logic [TID_W-1:0] woken_thread;
		logic             held;
		logic [TID_W-1:0] owner_now;
		phase_t           lock_phase;
	} rsp_t;

endpackage

FILE: rtl/mutex_lock_with_wait_stack.sv
// ----------------------------------------------------------------------------
// mutex_lock_with_wait_stack - single hardware lock with LIFO handoff
// Lock, try-lock, unlock and query requests; blocked lockers wait on a stack
// and an unlock hands the lock straight to the most recent waiter.
// ----------------------------------------------------------------------------
//  port    dir  width        role
//  start   in   1            request strobe, taken when busy is low
//  busy    out  1            always low: a request is taken every cycle
//  req     in   req_t        command and thread id
//  done    out  1            response strobe, one cycle per request
//  rsp     out  rsp_t        status, handoff thread and lock state
//
//  One request per cycle; its response shows in the cycle after acceptance.
//  The stack top sits in a register and the entry below it is prefetched
//  from the RAM, so back-to-back pops are served without waiting on the RAM.
//  Reset needs no clearing pass: stack entries are read only once written.
//  The receiver cannot stall; each response lasts exactly one cycle.
// ----------------------------------------------------------------------------
module mutex_lock_with_wait_stack #(
	parameter int WAIT_DEPTH = mlws_pkg::WAIT_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mlws_pkg::req_t req,
	output logic           done,
	output mlws_pkg::rsp_t rsp
);

	import mlws_pkg::*;

	localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
	localparam int ADDR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

	phase_t             phase_q, nxt_phase;
	logic [TID_W-1:0]   owner_q, nxt_owner;
	logic [CNT_W-1:0]   count_q, nxt_count;
	logic [TID_W-1:0]   top_q, nxt_top;
	logic [CNT_W-1:0]   rd_idx;
	logic [ADDR_W-1:0]  rd_addr;
	logic [TID_W-1:0]   below_top;
	logic               push;
	logic               accept;
	rsp_t               rsp_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stack body: every push is written, the entry under the top is prefetched
	mlws_ram #(
		.WIDTH (TID_W),
		.DEPTH (WAIT_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (req.thread_id),
		.rd_addr (rd_addr),
		.rd_data (below_top)
	);

	// Address the entry that will lie under the top after this cycle
	assign rd_idx  = nxt_count - CNT_W'(1) - CNT_W'(1);
	assign rd_addr = (nxt_count > CNT_W'(1)) ? rd_idx[ADDR_W-1:0] : '0;

	// Decode the request against the current lock state
	always_comb begin
		nxt_phase = phase_q;
		nxt_owner = owner_q;
		nxt_count = count_q;
		nxt_top   = top_q;
		push      = 1'b0;
		rsp_d     = '0;
		rsp_d.status = ST_OK;
		if (accept) begin
			case (req.cmd)
				CMD_LOCK: begin
					if (req.thread_id == '0) begin
						rsp_d.status = ST_NO_THREAD;
					end else if (phase_q == PH_UNLOCKED) begin
						nxt_owner = req.thread_id;
						nxt_phase = PH_LOCKED;
					end else if (count_q == CNT_W'(WAIT_DEPTH)) begin
						rsp_d.status = ST_FULL;
					end else begin
						push         = 1'b1;
						nxt_top      = req.thread_id;
						nxt_count    = count_q + CNT_W'(1);
						nxt_phase    = PH_CONTENDED;
						rsp_d.status = ST_QUEUED;
					end
				end
				CMD_TRY: begin
					if (phase_q != PH_UNLOCKED) begin
						rsp_d.status = ST_BUSY;
					end else if (req.thread_id == '0) begin
						rsp_d.status = ST_NO_THREAD;
					end else begin
						nxt_owner = req.thread_id;
						nxt_phase = PH_LOCKED;
					end
				end
				CMD_UNLOCK: begin
					if (req.thread_id == '0) begin
						rsp_d.status = ST_NO_THREAD;
					end else if (owner_q != req.thread_id) begin
						rsp_d.status = ST_NOT_OWNER;
					end else if (count_q != '0) begin
						// hand the lock to the latest waiter, phase stays contended
						nxt_count          = count_q - CNT_W'(1);
						nxt_owner          = top_q;
						nxt_top            = below_top;
						rsp_d.woken_valid  = 1'b1;
						rsp_d.woken_thread = top_q;
					end else begin
						nxt_owner = '0;
						nxt_phase = PH_UNLOCKED;
					end
				end
				CMD_QUERY: begin
					rsp_d.status = ST_OK;
				end
				default: begin
					rsp_d.status = ST_OK;
				end
			endcase
		end
		rsp_d.held       = (nxt_phase != PH_UNLOCKED);
		rsp_d.owner_now  = nxt_owner;
		rsp_d.lock_phase = nxt_phase;
	end

	// Hold lock state, waiter count and the response strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNLOCKED;
			owner_q <= '0;
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			phase_q <= nxt_phase;
			owner_q <= nxt_owner;
			count_q <= nxt_count;
			done    <= accept;
		end
	end

	// Register the stack top and the response payload
	always_ff @(posedge clk) begin
		top_q <= nxt_top;
		rsp   <= rsp_d;
	end

	// A response follows exactly one accepted request
	a_done_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("response without a request");

	// A free lock has no owner and no waiters
	a_free_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UNLOCKED) |-> (owner_q == '0 && count_q == '0))
		else $error("free lock with owner or waiters");

	// Waiters exist only while the lock is contended
	a_waiters_contended: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (phase_q == PH_CONTENDED))
		else $error("waiters without contention");

	// The stack never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WAIT_DEPTH))
		else $error("wait stack overfilled");

	// A handoff makes the woken thread the owner of a contended lock
	a_handoff_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.woken_valid) |->
			(rsp.owner_now == rsp.woken_thread && rsp.lock_phase == PH_CONTENDED
			 && rsp.status == ST_OK))
		else $error("handoff state mismatch");

endmodule

FILE: rtl/mlws_ram.sv
// ----------------------------------------------------------------------------
// mlws_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mlws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on request, register every read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
